// ===== rtl/rs_erasure_parity_encoder_macros.svh =====
// Assertion macros for the Reed-Solomon erasure parity encoder.
// Used by the top level only; depends on nothing.
`ifndef RS_ERASURE_PARITY_ENCODER_MACROS_SVH
`define RS_ERASURE_PARITY_ENCODER_MACROS_SVH

`define RSE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rse_pkg.sv =====
// Package of the Reed-Solomon erasure parity encoder: field constants,
// register indexes and GF(256) helpers. Depends on nothing.
package rse_pkg;

    localparam logic [8:0] GF_POLY = 9'h11D;
    localparam int         GF_ORDER = 255;

    localparam logic [0:0] REG_DATA_SHARDS   = 1'b0;
    localparam logic [0:0] REG_PARITY_SHARDS = 1'b1;
    localparam int         CFG_IDX_W = 8;

    localparam logic [4:0] RST_DATA_SHARDS   = 5'd4;
    localparam logic [3:0] RST_PARITY_SHARDS = 4'd2;

    typedef logic [7:0] t_gf;

    // Command from controller to datapath.
    typedef struct packed {
        logic clear;     // clear accumulators
        logic acc;       // fold latched byte into accumulators
        logic tab_mul;   // r_num/r_den update with current k
        logic tab_init;  // start a new coefficient
        logic inv_init;  // load inverter with den
        logic inv_step;  // one square-and-multiply step
        logic tab_write; // write num*inv to table
    } t_cmd;

    function automatic t_gf gf_mul(input t_gf a, input t_gf b);
        logic [7:0] x;
        logic [7:0] r;
        x = a;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x;
            x = x[7] ? ((x << 1) ^ GF_POLY[7:0]) : (x << 1);
        end
        return r;
    endfunction

endpackage

// ===== rtl/rse_stream_if.sv =====
// Valid/ready interfaces for the data, parity and configuration channels.
// Depends on nothing.
interface rse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_block;
    modport source (output valid, output data_byte, output end_of_block, input ready);
    modport sink (input valid, input data_byte, input end_of_block, output ready);
endinterface

interface rse_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] parity_index;
    logic [7:0] parity_byte;
    logic       last_of_column;
    logic       last_of_block;
    modport source (output valid, output parity_index, output parity_byte,
                    output last_of_column, output last_of_block, input ready);
    modport sink (input valid, input parity_index, input parity_byte,
                  input last_of_column, input last_of_block, output ready);
endinterface

interface rse_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rse_ram.sv =====
// Generic single-port-write, registered-read RAM.
// Depends on nothing.
module rse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rse_datapath.sv =====
// Datapath: table build arithmetic, per-parity accumulators.
// Depends on rse_pkg.
module rse_datapath #(
    parameter int MAX_PARITY = 8,
    parameter int PW = 3
) (
    input  logic              i_clk,
    input  rse_pkg::t_cmd     i_cmd,
    input  logic [7:0]        i_target,
    input  logic [7:0]        i_xi,
    input  logic [7:0]        i_xk,
    input  logic [7:0]        i_byte,
    input  logic [PW-1:0]     i_acc_sel,
    input  logic [7:0]        i_coef,
    input  logic [PW-1:0]     i_rd_sel,
    output logic [7:0]        o_tab_val,
    output logic [7:0]        o_acc_val
);
    logic [7:0] r_num, r_den, r_base, r_res, n_res;
    logic [7:0] r_acc [MAX_PARITY];
    logic [7:0] w_prod;

    assign w_prod = rse_pkg::gf_mul(i_coef, i_byte);
    assign n_res  = rse_pkg::gf_mul(r_res, r_base);

    always_ff @(posedge i_clk) begin
        if (i_cmd.tab_init) begin
            r_num <= 8'd1;
            r_den <= 8'd1;
        end else if (i_cmd.tab_mul) begin
            r_num <= rse_pkg::gf_mul(r_num, i_target ^ i_xk);
            r_den <= rse_pkg::gf_mul(r_den, i_xi ^ i_xk);
        end
        // a^254 = product of a^2, a^4, ... a^128: seven steps.
        if (i_cmd.inv_init) begin
            r_base <= rse_pkg::gf_mul(r_den, r_den);
            r_res  <= 8'd1;
        end else if (i_cmd.inv_step) begin
            r_res  <= n_res;
            r_base <= rse_pkg::gf_mul(r_base, r_base);
        end
        for (int j = 0; j < MAX_PARITY; j++) begin
            if (i_cmd.clear) r_acc[j] <= '0;
            else if (i_cmd.acc && i_acc_sel == PW'(j)) r_acc[j] <= r_acc[j] ^ w_prod;
        end
    end

    assign o_tab_val = rse_pkg::gf_mul(r_num, r_res);
    assign o_acc_val = r_acc[i_rd_sel];
endmodule

// ===== rtl/rse_ctrl.sv =====
// Controller state machine: table build sequencing, per-byte parity loop, emission.
// Depends on rse_pkg.
module rse_ctrl #(
    parameter int MAX_DATA = 16,
    parameter int DW = 4,
    parameter int PW = 3,
    parameter int AW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [DW:0]       i_n,
    input  logic [PW:0]       i_m,
    input  logic              i_in_valid,
    input  logic [7:0]        i_in_byte,
    input  logic              i_in_eob,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_out_index,
    output logic              o_out_loc,
    output logic              o_out_lob,
    output logic              o_busy,
    output rse_pkg::t_cmd     o_cmd,
    output logic [7:0]        o_target,
    output logic [7:0]        o_xi,
    output logic [7:0]        o_xk,
    output logic [7:0]        o_byte,
    output logic [PW-1:0]     o_acc_sel,
    output logic [PW-1:0]     o_rd_sel,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [AW-1:0]     o_raddr
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_TMUL = 8'b00000010, S_INV  = 8'b00000100,
        S_TWR  = 8'b00001000, S_RD   = 8'b00010000, S_ACC  = 8'b00100000,
        S_EMIT = 8'b01000000, S_TINI = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic r_valid, n_valid;
    logic [PW-1:0] r_j, n_j;
    logic [DW-1:0] r_i, n_i, r_k, n_k, r_pos, n_pos;
    logic [2:0] r_st, n_st;
    logic [7:0] r_byte, n_byte;
    logic r_eob, n_eob, r_ov, n_ov;
    rse_pkg::t_cmd w_cmd;

    logic [DW:0] w_n1;
    assign w_n1 = i_n - 1'b1;
    assign o_target = 8'(i_n) + 8'(r_j) + 8'd1;
    assign o_xi = 8'(r_i) + 8'd1;
    assign o_xk = 8'(r_k) + 8'd1;
    assign o_byte = r_byte;
    assign o_acc_sel = r_j;
    assign o_rd_sel = r_j;
    assign o_waddr = AW'(32'(r_j) * MAX_DATA + 32'(r_i));
    assign o_raddr = AW'(32'(r_j) * MAX_DATA + 32'(r_pos));
    assign o_we = (r_state == S_TWR);
    assign o_in_ready = (r_state == S_IDLE) && !r_ov && !i_cfg_we;
    assign o_out_valid = r_ov;
    assign o_out_index = 3'(r_j);
    assign o_out_loc = (r_j == PW'(i_m - 1'b1));
    assign o_out_lob = o_out_loc && r_eob;
    assign o_busy = (r_state != S_IDLE) || r_ov;
    assign o_cmd = w_cmd;

    always_comb begin
        n_state = r_state; n_valid = r_valid; n_j = r_j; n_i = r_i; n_k = r_k;
        n_pos = r_pos; n_st = r_st; n_byte = r_byte; n_eob = r_eob; n_ov = r_ov;
        w_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (r_ov) begin
                    if (i_out_ready) begin
                        if (r_j == PW'(i_m - 1'b1)) begin
                            n_ov = 1'b0; n_j = '0;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end else if (i_cfg_we) begin
                    n_valid = 1'b0; n_pos = '0; w_cmd.clear = 1'b1;
                end else if (i_in_valid) begin
                    n_byte = i_in_byte; n_eob = i_in_eob; n_j = '0;
                    if (32'(r_pos) >= 32'(i_n)) n_pos = '0;
                    if (!r_valid && i_m != 0) begin
                        n_i = '0; n_state = S_TINI;
                    end else begin
                        n_valid = 1'b1;
                        n_state = (i_m == 0) ? S_EMIT : S_RD;
                    end
                end
            end
            S_TINI: begin
                w_cmd.tab_init = 1'b1; n_k = '0; n_state = S_TMUL;
            end
            S_TMUL: begin
                if (r_k != r_i) w_cmd.tab_mul = 1'b1;
                if (r_k == DW'(w_n1)) begin
                    n_st = '0; n_state = S_INV;
                end else n_k = r_k + 1'b1;
            end
            S_INV: begin
                // The first pass loads the finished denominator; seven square-and-multiply steps then invert it.
                if (r_st == 3'd0) w_cmd.inv_init = 1'b1;
                else w_cmd.inv_step = 1'b1;
                n_st = r_st + 1'b1;
                if (r_st == 3'd7) n_state = S_TWR;
            end
            S_TWR: begin
                if (r_i == DW'(w_n1)) begin
                    n_i = '0;
                    if (r_j == PW'(i_m - 1'b1)) begin
                        n_j = '0; n_valid = 1'b1; n_state = S_RD;
                    end else begin
                        n_j = r_j + 1'b1; n_state = S_TINI;
                    end
                end else begin
                    n_i = r_i + 1'b1; n_state = S_TINI;
                end
            end
            S_RD: n_state = S_ACC;
            S_ACC: begin
                w_cmd.acc = 1'b1;
                if (r_j == PW'(i_m - 1'b1)) begin
                    n_j = '0; n_state = S_EMIT;
                end else begin
                    n_j = r_j + 1'b1; n_state = S_RD;
                end
            end
            S_EMIT: begin
                n_state = S_IDLE;
                if (32'(r_pos) + 1 >= 32'(i_n)) begin
                    n_pos = '0;
                    if (i_m != 0) n_ov = 1'b1;
                end else n_pos = r_pos + 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_ov && i_out_ready && r_j == PW'(i_m - 1'b1)) w_cmd.clear = 1'b1;
        if (!i_rst_n) w_cmd.clear = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0; r_j <= '0; r_pos <= '0; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_j <= n_j; r_pos <= n_pos;
            r_ov <= n_ov;
        end
        r_i <= n_i; r_k <= n_k; r_st <= n_st; r_byte <= n_byte; r_eob <= n_eob;
    end
endmodule

// ===== rtl/rs_erasure_parity_encoder.sv =====
// Reed-Solomon GF(256) erasure parity encoder, top level.
// Per byte, one table read and accumulate per parity shard; a column-closing byte adds m output words.
// After reset or configuration, the first byte first builds the n*m table.
// Synchronous active-low reset clears control.
// Depends on rse_pkg, rse_stream_if, rse_ram, rse_ctrl, rse_datapath and macros.
`include "rs_erasure_parity_encoder_macros.svh"
module rs_erasure_parity_encoder #(
    parameter int MAX_DATA = 16,
    parameter int MAX_PARITY = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rse_in_if.sink     in_ch,
    rse_out_if.source  out_ch,
    rse_cfg_if.sink    cfg_ch
);
    localparam int DW = $clog2(MAX_DATA + 1);
    localparam int PW = (MAX_PARITY > 1) ? $clog2(MAX_PARITY) : 1;
    localparam int AW = $clog2(MAX_DATA * MAX_PARITY);

    logic [4:0] r_data_shards;
    logic [3:0] r_parity_shards;
    logic [DW:0] w_n;
    logic [PW:0] w_m;
    logic w_busy, w_cfg_we, w_we;
    rse_pkg::t_cmd w_cmd;
    logic [7:0] w_target, w_xi, w_xk, w_byte, w_coef, w_tab, w_acc;
    logic [PW-1:0] w_acc_sel, w_rd_sel;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [2:0] w_idx;

    assign cfg_ch.ready = !w_busy;
    assign w_cfg_we = cfg_ch.valid && cfg_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_shards <= rse_pkg::RST_DATA_SHARDS;
            r_parity_shards <= rse_pkg::RST_PARITY_SHARDS;
        end else if (w_cfg_we && cfg_ch.index[7:1] == '0) begin
            if (cfg_ch.index[0] == rse_pkg::REG_DATA_SHARDS) r_data_shards <= cfg_ch.data[4:0];
            else r_parity_shards <= cfg_ch.data[3:0];
        end
    end

    always_comb begin
        if (r_data_shards == '0) w_n = (DW+1)'(1);
        else if (32'(r_data_shards) > MAX_DATA) w_n = (DW+1)'(MAX_DATA);
        else w_n = (DW+1)'(r_data_shards);
        if (32'(r_parity_shards) > MAX_PARITY) w_m = (PW+1)'(MAX_PARITY);
        else w_m = (PW+1)'(r_parity_shards);
    end

    rse_ctrl #(.MAX_DATA(MAX_DATA), .DW(DW), .PW(PW), .AW(AW)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(w_cfg_we && cfg_ch.index[7:1] == '0),
        .i_n(w_n), .i_m(w_m),
        .i_in_valid(in_ch.valid), .i_in_byte(in_ch.data_byte), .i_in_eob(in_ch.end_of_block),
        .o_in_ready(in_ch.ready), .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .o_out_index(w_idx), .o_out_loc(out_ch.last_of_column),
        .o_out_lob(out_ch.last_of_block), .o_busy(w_busy), .o_cmd(w_cmd),
        .o_target(w_target), .o_xi(w_xi), .o_xk(w_xk), .o_byte(w_byte),
        .o_acc_sel(w_acc_sel), .o_rd_sel(w_rd_sel), .o_we(w_we),
        .o_waddr(w_waddr), .o_raddr(w_raddr)
    );

    rse_ram #(.WIDTH(8), .DEPTH(MAX_DATA * MAX_PARITY)) u_tab (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_tab),
        .i_raddr(w_raddr), .o_rdata(w_coef)
    );

    rse_datapath #(.MAX_PARITY(MAX_PARITY), .PW(PW)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_target(w_target), .i_xi(w_xi), .i_xk(w_xk),
        .i_byte(w_byte), .i_acc_sel(w_acc_sel), .i_coef(w_coef), .i_rd_sel(w_rd_sel),
        .o_tab_val(w_tab), .o_acc_val(w_acc)
    );

    assign out_ch.parity_index = w_idx;
    assign out_ch.parity_byte = w_acc;

    `RSE_ASSERT_IMPL(a_no_in_while_out, i_clk, i_rst_n, out_ch.valid, !in_ch.ready,
        "input accepted while parity pending")
    `RSE_ASSERT_IMPL(a_lob_needs_loc, i_clk, i_rst_n, out_ch.valid && out_ch.last_of_block,
        out_ch.last_of_column, "last_of_block without last_of_column")
    `RSE_ASSERT_NEXT(a_cfg_idle, i_clk, i_rst_n, w_cfg_we, !out_ch.valid,
        "configuration accepted while busy")
endmodule

// ===== bench/rs_erasure_parity_encoder_tb_if.sv =====
`timescale 1ns / 1ps
// Packed word types of the bench for the byte and parity channels.
// Depends on nothing.
package rse_tb_types;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_block;
    } t_byte_word;
    typedef struct packed {
        logic [2:0] parity_index;
        logic [7:0] parity_byte;
        logic       last_of_column;
        logic       last_of_block;
    } t_parity_word;
endpackage

// ===== bench/rs_erasure_parity_encoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench of the GF(256) Reed-Solomon parity encoder: random and
// directed columns under several shard settings, checked against a local model.
// Depends on rse_pkg, rse_stream_if, rse_tb_types and rs_erasure_parity_encoder.
module rs_erasure_parity_encoder_tb;

    localparam int MAXD = 16;
    localparam int MAXP = 8;
    localparam int WATCHDOG = 200000;

    logic i_clk;
    logic i_rst_n;
    rse_in_if  in_ch();
    rse_out_if out_ch();
    rse_cfg_if cfg_ch();

    rs_erasure_parity_encoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
    );

    always begin
        i_clk = 1'b1; #10;
        i_clk = 1'b0; #10;
    end

    logic [4:0]   n_reg;
    logic [3:0]   m_reg;
    logic [7:0]   coef [MAXP][MAXD];
    logic         coef_ok;
    logic [7:0]   acc [MAXP];
    int           pos;
    rse_tb_types::t_byte_word   pending_bytes[$];
    rse_tb_types::t_parity_word expected_parity[$];
    int           errors;
    int           idle_cycles;
    bit           timed_out;
    int           in_wait;
    int           out_wait;

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] x;
        logic [7:0] r;
        x = {1'b0, a};
        r = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r = r ^ x[7:0];
            x = x << 1;
            if (x[8]) x = x ^ 9'h11D;
        end
        return r;
    endfunction

    function automatic logic [7:0] ginv(input logic [7:0] a);
        logic [7:0] r;
        r = 8'd1;
        for (int i = 0; i < 254; i++) r = gmul(r, a);
        return r;
    endfunction

    function automatic int shards_n();
        int n;
        n = n_reg;
        if (n < 1) n = 1;
        if (n > MAXD) n = MAXD;
        return n;
    endfunction

    function automatic int shards_m();
        int m;
        m = m_reg;
        if (m > MAXP) m = MAXP;
        return m;
    endfunction

    task automatic build_coefficients();
        int n;
        int m;
        logic [7:0] num;
        logic [7:0] den;
        n = shards_n();
        m = shards_m();
        for (int j = 0; j < m; j++) begin
            for (int i = 0; i < n; i++) begin
                num = 8'd1;
                den = 8'd1;
                for (int k = 0; k < n; k++) begin
                    if (k != i) begin
                        num = gmul(num, 8'(n + j + 1) ^ 8'(k + 1));
                        den = gmul(den, 8'(i + 1) ^ 8'(k + 1));
                    end
                end
                coef[j][i] = gmul(num, ginv(den));
            end
        end
        coef_ok = 1'b1;
    endtask

    task automatic predict_parity(input rse_tb_types::t_byte_word w);
        int n;
        int m;
        rse_tb_types::t_parity_word p;
        n = shards_n();
        m = shards_m();
        if (!coef_ok) build_coefficients();
        if (pos >= n) pos = 0;
        for (int j = 0; j < m; j++) acc[j] ^= gmul(coef[j][pos], w.data_byte);
        pos++;
        if (pos >= n) begin
            for (int j = 0; j < m; j++) begin
                p.parity_index = 3'(j);
                p.parity_byte = acc[j];
                p.last_of_column = (j == m - 1);
                p.last_of_block = (j == m - 1) && w.end_of_block;
                expected_parity.push_back(p);
                acc[j] = 8'd0;
            end
            pos = 0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG && !timed_out) begin
                timed_out = 1'b1;
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Driver: accepted words are predicted at the rising edge, new ones offered at the falling.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            predict_parity(pending_bytes.pop_front());
            in_wait = $urandom_range(0, 13);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_wait > 0) begin
            in_ch.valid <= 1'b0;
            in_wait = in_wait - 1;
        end else if (pending_bytes.size() > 0) begin
            in_ch.valid <= 1'b1;
            in_ch.data_byte <= pending_bytes[0].data_byte;
            in_ch.end_of_block <= pending_bytes[0].end_of_block;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        rse_tb_types::t_parity_word got;
        rse_tb_types::t_parity_word exp_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.parity_index, out_ch.parity_byte,
                   out_ch.last_of_column, out_ch.last_of_block};
            if (expected_parity.size() == 0) begin
                errors++;
                $display("%0t: expected no parity word, got %h", $time, got);
            end else begin
                exp_w = expected_parity.pop_front();
                if (got !== exp_w) begin
                    errors++;
                    $display({"%0t: expected idx %0d byte %h loc %b lob %b, ",
                              "got idx %0d byte %h loc %b lob %b"},
                        $time, exp_w.parity_index, exp_w.parity_byte, exp_w.last_of_column,
                        exp_w.last_of_block, got.parity_index, got.parity_byte,
                        got.last_of_column, got.last_of_block);
                end
            end
            out_wait = $urandom_range(0, 13);
        end
    end

    always @(negedge i_clk) begin
        if (out_wait > 0) begin
            out_ch.ready <= 1'b0;
            out_wait = out_wait - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    task automatic write_register(input logic [7:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        // Ready is stable from the falling edge to the next rising edge.
        while (!cfg_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        if (idx == 8'(rse_pkg::REG_DATA_SHARDS)) n_reg = value[4:0];
        else if (idx == 8'(rse_pkg::REG_PARITY_SHARDS)) m_reg = value[3:0];
        if (idx <= 8'(rse_pkg::REG_PARITY_SHARDS)) begin
            coef_ok = 1'b0;
            pos = 0;
            for (int j = 0; j < MAXP; j++) acc[j] = 8'd0;
        end
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        int n;
        n = shards_n();
        while (pending_bytes.size() > 0 || expected_parity.size() > 0 || in_ch.valid)
            @(posedge i_clk);
        repeat (MAXP * n * (n + 10) + 64) @(posedge i_clk);
    endtask

    task automatic queue_columns(input int cols, input bit full_range);
        int n;
        rse_tb_types::t_byte_word w;
        n = shards_n();
        for (int c = 0; c < cols; c++) begin
            for (int i = 0; i < n; i++) begin
                w.data_byte = full_range ? 8'($urandom) : (($urandom & 1) ? 8'hFF : 8'h00);
                w.end_of_block = 1'($urandom);
                pending_bytes.push_back(w);
            end
        end
    endtask

    initial begin
        int n_set [7] = '{1, 16, 0, 31, 5, 3, 9};
        int m_set [7] = '{8, 1, 3, 15, 0, 4, 7};
        int sent;
        rse_tb_types::t_byte_word w;
        errors = 0;
        timed_out = 1'b0;
        in_wait = 0;
        out_wait = 0;
        n_reg = rse_pkg::RST_DATA_SHARDS;
        m_reg = rse_pkg::RST_PARITY_SHARDS;
        coef_ok = 1'b0;
        pos = 0;
        for (int j = 0; j < MAXP; j++) acc[j] = 8'd0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = 8'd0;
        in_ch.end_of_block = 1'b0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = 8'd0;
        cfg_ch.data = 8'd0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset setting with extremes and a block end mid-column.
        w = '{8'h00, 1'b1}; pending_bytes.push_back(w);
        w = '{8'hFF, 1'b0}; pending_bytes.push_back(w);
        w = '{8'h01, 1'b0}; pending_bytes.push_back(w);
        w = '{8'h80, 1'b1}; pending_bytes.push_back(w);
        w = '{8'hFF, 1'b0}; pending_bytes.push_back(w);
        w = '{8'hFF, 1'b0}; pending_bytes.push_back(w);
        w = '{8'hAA, 1'b0}; pending_bytes.push_back(w);
        w = '{8'h55, 1'b1}; pending_bytes.push_back(w);
        drain();
        // A partial column dropped by a write, and an unknown index ignored.
        w = '{8'h12, 1'b0}; pending_bytes.push_back(w);
        drain();
        write_register(8'd7, 8'h3C);
        write_register(8'(rse_pkg::REG_PARITY_SHARDS), 8'd2);

        sent = 9;
        foreach (n_set[k]) begin
            write_register(8'(rse_pkg::REG_DATA_SHARDS), 8'(n_set[k]));
            write_register(8'(rse_pkg::REG_PARITY_SHARDS), 8'(m_set[k]));
            if ($urandom_range(0, 1)) write_register(8'($urandom_range(2, 255)), 8'($urandom));
            queue_columns(1, 1'b0);
            sent += shards_n();
            while (sent < 9 + 64 * (k + 1)) begin
                queue_columns(1, 1'b1);
                sent += shards_n();
                if ($urandom_range(0, 9) == 0) begin
                    w.data_byte = 8'($urandom);
                    w.end_of_block = 1'($urandom);
                    pending_bytes.push_back(w);
                    sent++;
                end
            end
            drain();
        end
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
